FILE: rtl/rpr_pkg.sv
`default_nettype none
package rpr_pkg;

  localparam int PW = 13;          // pulse width field
  localparam int EW = 16;          // epsilon field
  localparam int QW = 16;          // Q1.15 output
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  // Quotient bits of the scaled division (r * 2^15).
  localparam int DIV_STEPS = 15;
  localparam logic [QW-1:0] Q_MAX = 16'd32767;

  localparam logic [CFG_IW-1:0] REG_STEER_MIN    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_STEER_MAX    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_THROTTLE_MIN = 3'd2;
  localparam logic [CFG_IW-1:0] REG_THROTTLE_MAX = 3'd3;
  localparam logic [CFG_IW-1:0] REG_AUX_THRESH   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_EPSILON      = 3'd5;

  localparam logic [PW-1:0] STEER_MIN_RST = 13'd1000;
  localparam logic [PW-1:0] STEER_MAX_RST = 13'd2000;
  localparam logic [PW-1:0] THR_MIN_RST   = 13'd1000;
  localparam logic [PW-1:0] THR_MAX_RST   = 13'd2000;
  localparam logic [PW-1:0] AUX_RST       = 13'd1500;
  localparam logic [EW-1:0] EPS_RST       = 16'd3277;

  typedef struct packed {
    logic [PW-1:0] steer_pulse;
    logic [PW-1:0] throttle_pulse;
    logic [PW-1:0] arm_pulse;
    logic [PW-1:0] calib_pulse;
  } frame_t;

  typedef struct packed {
    logic                 link_up;
    logic                 is_armed;
    logic signed [QW-1:0] steering_out;
    logic signed [QW-1:0] throttle_out;
  } result_t;

  typedef struct packed {
    logic       load_frame;
    logic       filt;
    logic [1:0] ch;
    logic       flags;
    logic       widen;
    logic       map_set;
    logic       map_chk;
    logic       div_step;
    logic       map_end;
    logic       map_ch;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/rpr_div.sv
`default_nettype none
module rpr_div import rpr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              start,
  input  wire logic              step,
  input  wire logic [PW-1:0]     dividend,
  input  wire logic [PW-1:0]     divisor,
  output logic [DIV_STEPS-1:0]   quotient
);

  // Restoring division of dividend * 2^DIV_STEPS by divisor, one bit per
  // step. The dividend is below the divisor whenever the result is used.
  logic [PW-1:0]        rem;
  logic [PW-1:0]        den;
  logic [DIV_STEPS-1:0] q;
  logic [PW:0]          trial;

  assign trial = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      den <= divisor;
      q   <= '0;
    end else if (step) begin
      if (trial >= {1'b0, den}) begin
        rem <= PW'(trial - {1'b0, den});
        q   <= {q[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem <= trial[PW-1:0];
        q   <= {q[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  assign quotient = q;

endmodule
`default_nettype wire

FILE: rtl/rpr_datapath.sv
`default_nettype none
module rpr_datapath import rpr_pkg::*; #(
  parameter int unsigned PULSE_TIMEOUT_US = 5000
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire frame_t            frame,
  input  wire logic              cfg_write,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output result_t                result
);

  localparam logic [PW-1:0] TIMEOUT = PW'(PULSE_TIMEOUT_US);

  // Configuration registers.
  logic [PW-1:0] steer_min, steer_max, thr_min, thr_max, aux_thresh;
  logic [EW-1:0] epsilon;

  // Conditioner state: channel 0 steering, 1 throttle, 2 arm, 3 calibrate.
  logic [PW-1:0] frm [4];
  logic [PW-1:0] raw_last [4];
  logic [PW-1:0] acc [4];
  logic [PW-1:0] lower [2];
  logic [PW-1:0] upper [2];
  logic          link, arm;

  // Mapping intermediates.
  logic [PW:0]          map_an;
  logic [PW-1:0]        map_as;
  logic                 map_neg, map_zero, map_sat;
  logic signed [QW-1:0] steer_res, thr_res;
  logic [DIV_STEPS-1:0] quotient;

  // Glitch filter for the selected channel.
  logic [PW-1:0]   f_v, f_prev, f_d;
  logic [28:0]     f_prod;
  logic            f_take;

  always_comb begin
    f_v    = frm[cmd.ch];
    f_prev = raw_last[cmd.ch];
    f_d    = (f_v > f_prev) ? (f_v - f_prev) : (f_prev - f_v);
    f_prod = 29'(epsilon) * 29'(f_prev);
    f_take = {f_d, 16'b0} <= f_prod;
  end

  logic link_next;
  assign link_next = link | ((acc[0] != '0) & (acc[1] != '0) & (acc[2] != '0));

  // Edge widening while calibrating: outer quarter zones of the nominal range.
  logic          calib_on;
  logic [PW-1:0] nom_lo [2];
  logic [PW-1:0] nom_hi [2];
  logic          lo_take [2];
  logic          hi_take [2];

  assign calib_on  = link & ~arm & (acc[3] >= aux_thresh);
  assign nom_lo[0] = steer_min;
  assign nom_hi[0] = steer_max;
  assign nom_lo[1] = thr_min;
  assign nom_hi[1] = thr_max;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      lo_take[c] = ({acc[c], 2'b0} < ({2'b0, nom_lo[c]} + {1'b0, nom_lo[c], 1'b0}
                                      + {2'b0, nom_hi[c]}))
                   && ((acc[c] < lower[c]) || (lower[c] == nom_lo[c]));
      hi_take[c] = ({acc[c], 2'b0} > ({2'b0, nom_hi[c]} + {1'b0, nom_hi[c], 1'b0}
                                      + {2'b0, nom_lo[c]}))
                   && ((acc[c] > upper[c]) || (upper[c] == nom_hi[c]));
    end
  end

  // Mapping set-up: num = 2v - lo - hi, span = hi - lo.
  logic signed [QW-1:0] m_num;
  logic signed [PW:0]   m_span;
  logic [PW-1:0]        m_lo, m_hi, m_v;

  always_comb begin
    m_lo   = lower[cmd.map_ch];
    m_hi   = upper[cmd.map_ch];
    m_v    = acc[cmd.map_ch];
    m_num  = $signed({2'b00, m_v, 1'b0}) - $signed({3'b000, m_lo})
             - $signed({3'b000, m_hi});
    m_span = $signed({1'b0, m_hi}) - $signed({1'b0, m_lo});
  end

  logic [QW-1:0] m_mag;
  logic [QW-1:0] m_val;

  always_comb begin
    m_mag = map_sat ? Q_MAX : QW'(quotient);
    if (map_zero || !(link && arm)) begin
      m_val = '0;
    end else if (map_neg) begin
      m_val = QW'(~m_mag + 1'b1);
    end else begin
      m_val = m_mag;
    end
  end

  rpr_div u_div (
    .clk      (clk),
    .start    (cmd.map_chk),
    .step     (cmd.div_step),
    .dividend (map_an[PW-1:0]),
    .divisor  (map_as),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_min  <= STEER_MIN_RST;
      steer_max  <= STEER_MAX_RST;
      thr_min    <= THR_MIN_RST;
      thr_max    <= THR_MAX_RST;
      aux_thresh <= AUX_RST;
      epsilon    <= EPS_RST;
      lower[0]   <= STEER_MIN_RST;
      upper[0]   <= STEER_MAX_RST;
      lower[1]   <= THR_MIN_RST;
      upper[1]   <= THR_MAX_RST;
      for (int c = 0; c < 4; c++) begin
        raw_last[c] <= '0;
        acc[c]      <= '0;
      end
      link <= 1'b0;
      arm  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_STEER_MIN: begin
            steer_min <= cfg_data[PW-1:0];
            lower[0]  <= cfg_data[PW-1:0];
          end
          REG_STEER_MAX: begin
            steer_max <= cfg_data[PW-1:0];
            upper[0]  <= cfg_data[PW-1:0];
          end
          REG_THROTTLE_MIN: begin
            thr_min  <= cfg_data[PW-1:0];
            lower[1] <= cfg_data[PW-1:0];
          end
          REG_THROTTLE_MAX: begin
            thr_max  <= cfg_data[PW-1:0];
            upper[1] <= cfg_data[PW-1:0];
          end
          REG_AUX_THRESH: aux_thresh <= cfg_data[PW-1:0];
          REG_EPSILON:    epsilon    <= cfg_data[EW-1:0];
          default: ;
        endcase
      end
      if (cmd.filt) begin
        raw_last[cmd.ch] <= f_v;
        if (f_take) begin
          acc[cmd.ch] <= f_v;
        end
      end
      if (cmd.flags) begin
        link <= link_next;
        if (link_next) begin
          arm <= acc[2] >= aux_thresh;
        end
      end
      if (cmd.widen && calib_on) begin
        for (int c = 0; c < 2; c++) begin
          if (lo_take[c]) lower[c] <= acc[c];
          if (hi_take[c]) upper[c] <= acc[c];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      // Widths beyond the timeout count as a missing pulse.
      frm[0] <= (frame.steer_pulse    > TIMEOUT) ? '0 : frame.steer_pulse;
      frm[1] <= (frame.throttle_pulse > TIMEOUT) ? '0 : frame.throttle_pulse;
      frm[2] <= (frame.arm_pulse      > TIMEOUT) ? '0 : frame.arm_pulse;
      frm[3] <= (frame.calib_pulse    > TIMEOUT) ? '0 : frame.calib_pulse;
    end
    if (cmd.map_set) begin
      map_an  <= m_num[QW-1] ? (PW+1)'(~m_num + 1'b1) : (PW+1)'(m_num);
      map_as  <= m_span[PW] ? PW'(~m_span + 1'b1) : m_span[PW-1:0];
      map_neg <= m_num[QW-1] ^ m_span[PW];
    end
    if (cmd.map_chk) begin
      map_zero <= (map_as == '0)
                  || ({map_an, 16'b0} < (30'(epsilon) * 30'(map_as)));
      map_sat  <= map_an >= {1'b0, map_as};
    end
    if (cmd.map_end) begin
      if (cmd.map_ch) begin
        thr_res <= $signed(m_val);
      end else begin
        steer_res <= $signed(m_val);
      end
    end
    if (cmd.out_load) begin
      result.link_up      <= link;
      result.is_armed     <= arm;
      result.steering_out <= steer_res;
      result.throttle_out <= thr_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.out_load | (result_valid & result_stall);
    end
  end

  assign sts.out_free = ~result_valid | ~result_stall;

endmodule
`default_nettype wire

FILE: rtl/rpr_ctrl.sv
`default_nettype none
module rpr_ctrl import rpr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic frame_valid,
  output logic      frame_stall,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILT  = 4'd1;
  localparam logic [3:0] S_FLAGS = 4'd2;
  localparam logic [3:0] S_WIDEN = 4'd3;
  localparam logic [3:0] S_MSET  = 4'd4;
  localparam logic [3:0] S_MCHK  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_MEND  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [3:0] DIV_LAST = 4'(DIV_STEPS - 1);

  logic [3:0] state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       mch, mch_next;

  assign frame_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    mch_next   = mch;
    cmd        = '0;
    cmd.ch     = cnt[1:0];
    cmd.map_ch = mch;
    unique case (state)
      S_IDLE: begin
        if (frame_valid) begin
          cmd.load_frame = 1'b1;
          cnt_next       = '0;
          state_next     = S_FILT;
        end
      end
      S_FILT: begin
        cmd.filt = 1'b1;
        cnt_next = cnt + 4'd1;
        if (cnt[1:0] == 2'd3) begin
          state_next = S_FLAGS;
        end
      end
      S_FLAGS: begin
        cmd.flags  = 1'b1;
        state_next = S_WIDEN;
      end
      S_WIDEN: begin
        cmd.widen  = 1'b1;
        mch_next   = 1'b0;
        state_next = S_MSET;
      end
      S_MSET: begin
        cmd.map_set = 1'b1;
        state_next  = S_MCHK;
      end
      S_MCHK: begin
        cmd.map_chk = 1'b1;
        cnt_next    = '0;
        state_next  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 4'd1;
        if (cnt == DIV_LAST) begin
          state_next = S_MEND;
        end
      end
      S_MEND: begin
        cmd.map_end = 1'b1;
        if (mch) begin
          state_next = S_DONE;
        end else begin
          mch_next   = 1'b1;
          state_next = S_MSET;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      mch   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      mch   <= mch_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rc_pwm_receiver_conditioner.sv
// RC receiver conditioner. Each item on the frame channel holds four
// measured pulse widths (steering, throttle, arm and calibrate switches);
// each frame gives exactly one item on the result channel with the link and
// armed flags and the steering and throttle commands in Q1.15.
// An item is taken when valid is high and stall is low, on either channel.
// The configuration port writes one register per cycle with cfg_write high;
// writing a nominal edge register also reloads that channel's edge. Write
// only while no frame is being worked on.
// A frame passes through the glitch filter (one channel a cycle on a
// shared multiplier), then the link and armed flags, then calibration,
// then the mapping of each axis in turn, most of which is the restoring
// divider. A new frame is not accepted before the last one is through;
// frame_stall is high while a frame is in progress.
// The result sits in an output register: a new frame is accepted while it
// waits, and if the receiver still stalls when the next result is ready,
// the block holds that result and stalls the frame channel until room frees.
// Synchronous reset clears all history, flags and the result channel and
// restores the default configuration.
`default_nettype none
module rc_pwm_receiver_conditioner import rpr_pkg::*; #(
  parameter int unsigned PULSE_TIMEOUT_US = 5000
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              frame_valid,
  output logic                   frame_stall,
  input  wire frame_t            frame,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output result_t                result,
  input  wire logic              cfg_write,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  rpr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  rpr_datapath #(
    .PULSE_TIMEOUT_US (PULSE_TIMEOUT_US)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire

FILE: tb/tb_rc_pwm_receiver_conditioner.sv
module tb_rc_pwm_receiver_conditioner;
  import rpr_pkg::*;

  localparam int PULSE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS = 150;
  localparam int PRINT_LIMIT = 40;

  logic              clk;
  logic              rst = 1'b1;
  logic              frame_valid = 1'b0;
  logic              frame_stall;
  frame_t            frame = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result;
  logic              cfg_write = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  rc_pwm_receiver_conditioner i_dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Conditioner state as the testbench sees it.
  logic [PW-1:0] raw_prev [4];
  logic [PW-1:0] kept_width [4];
  logic [PW-1:0] edge_lo [2];
  logic [PW-1:0] edge_hi [2];
  logic [PW-1:0] nom_lo [2];
  logic [PW-1:0] nom_hi [2];
  logic [PW-1:0] arm_level;
  logic [EW-1:0] eps;
  bit            linked;
  bit            armed;

  frame_t  pending_frames [$];
  result_t predicted_results [$];
  logic [PW-1:0] cur_width [4];

  int  frames_queued = 0;
  int  frames_accepted = 0;
  int  mismatches = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_left = 0;
  bit  frame_taken = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  function automatic void apply_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    case (idx)
      REG_STEER_MIN: begin
        nom_lo[0] = data[PW-1:0];
        edge_lo[0] = data[PW-1:0];
      end
      REG_STEER_MAX: begin
        nom_hi[0] = data[PW-1:0];
        edge_hi[0] = data[PW-1:0];
      end
      REG_THROTTLE_MIN: begin
        nom_lo[1] = data[PW-1:0];
        edge_lo[1] = data[PW-1:0];
      end
      REG_THROTTLE_MAX: begin
        nom_hi[1] = data[PW-1:0];
        edge_hi[1] = data[PW-1:0];
      end
      REG_AUX_THRESH: arm_level = data[PW-1:0];
      REG_EPSILON: eps = data;
      default: ;
    endcase
  endfunction

  // Calibration lets an edge move out into the outer quarter of the nominal range.
  function automatic void widen_axis(input int ax);
    longint v, lo, hi;
    v = kept_width[ax];
    lo = nom_lo[ax];
    hi = nom_hi[ax];
    if (4 * v < 3 * lo + hi && (v < edge_lo[ax] || edge_lo[ax] == nom_lo[ax])) begin
      edge_lo[ax] = kept_width[ax];
    end
    if (4 * v > lo + 3 * hi && (v > edge_hi[ax] || edge_hi[ax] == nom_hi[ax])) begin
      edge_hi[ax] = kept_width[ax];
    end
  endfunction

  function automatic logic signed [QW-1:0] map_axis(input int ax);
    longint v, lo, hi, span, num, mag, thr, q;
    v = kept_width[ax];
    lo = edge_lo[ax];
    hi = edge_hi[ax];
    span = hi - lo;
    if (span == 0) begin
      return '0;
    end
    num = 2 * (v - lo) - span;
    if (span < 0) begin
      span = -span;
      num = -num;
    end
    mag = (num < 0) ? -num : num;
    thr = eps;
    if (mag * 65536 < thr * span) begin
      return '0;
    end
    q = (num * 32768) / span;
    if (q > 32767) q = 32767;
    if (q < -32767) q = -32767;
    return q[QW-1:0];
  endfunction

  function automatic result_t condition_frame(input frame_t f);
    logic [PW-1:0] w [4];
    longint gap, prev;
    result_t r;
    w[0] = f.steer_pulse;
    w[1] = f.throttle_pulse;
    w[2] = f.arm_pulse;
    w[3] = f.calib_pulse;
    for (int i = 0; i < 4; i++) begin
      if (w[i] > PULSE_LIMIT) w[i] = '0;
      prev = raw_prev[i];
      gap = (w[i] > raw_prev[i]) ? w[i] - raw_prev[i] : raw_prev[i] - w[i];
      if (gap * 65536 <= longint'(eps) * prev) kept_width[i] = w[i];
      raw_prev[i] = w[i];
    end
    if (!linked && kept_width[0] != 0 && kept_width[1] != 0 && kept_width[2] != 0) begin
      linked = 1'b1;
    end
    if (linked) armed = (kept_width[2] >= arm_level);
    if (linked && !armed && kept_width[3] >= arm_level) begin
      widen_axis(0);
      widen_axis(1);
    end
    r = '0;
    r.link_up = linked;
    r.is_armed = armed;
    if (linked && armed) begin
      r.steering_out = map_axis(0);
      r.throttle_out = map_axis(1);
    end
    return r;
  endfunction

  task automatic queue_frame(input int s, input int t, input int a, input int c);
    frame_t f;
    f.steer_pulse = s[PW-1:0];
    f.throttle_pulse = t[PW-1:0];
    f.arm_pulse = a[PW-1:0];
    f.calib_pulse = c[PW-1:0];
    pending_frames.push_back(f);
    frames_queued++;
  endtask

  // Mostly steady or jittering widths so that the glitch filter lets them
  // through, with jumps, switch flips and the odd out-of-range width.
  function automatic logic [PW-1:0] vary_width(input logic [PW-1:0] last, input int ch);
    int pick, delta, v;
    pick = $urandom_range(0, 99);
    v = last;
    if (pick < 55) begin
      v = last;
    end else if (pick < 80) begin
      delta = $urandom_range(0, 1 + last / 16);
      v = ($urandom_range(0, 1) != 0) ? v + delta : v - delta;
    end else if (pick < 92) begin
      if (ch >= 2) begin
        case ($urandom_range(0, 3))
          0: v = int'(arm_level) - 1;
          1: v = arm_level;
          2: v = int'(arm_level) + int'($urandom_range(1, 800));
          default: v = $urandom_range(0, arm_level);
        endcase
      end else begin
        v = $urandom_range(0, PULSE_LIMIT);
      end
    end else begin
      v = $urandom_range(0, 8191);
    end
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    return v[PW-1:0];
  endfunction

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    apply_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    while (frames_accepted != frames_queued || predicted_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_phase(input int n, input int s_pct, input int r_pct, input bit pressure);
    @(posedge clk);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    if (pressure) hold_left = HOLD_CYCLES;
    for (int k = 0; k < n; k++) begin
      for (int ch = 0; ch < 4; ch++) begin
        cur_width[ch] = vary_width(cur_width[ch], ch);
      end
      queue_frame(cur_width[0], cur_width[1], cur_width[2], cur_width[3]);
    end
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (!frame_valid || frame_taken) begin
      frame_taken = 1'b0;
      if (pending_frames.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        frame <= pending_frames.pop_front();
        frame_valid <= 1'b1;
      end else begin
        frame_valid <= 1'b0;
      end
    end
  end

  // The long hold-off lets the block fill up and stall its frame input.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (frame_valid && !frame_stall) begin
        predicted_results.push_back(condition_frame(frame));
        frame_taken = 1'b1;
        frames_accepted++;
      end
      if (result_valid && !result_stall) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result item with none expected", 0, 0);
        end else begin
          want = predicted_results.pop_front();
          if (result.link_up !== want.link_up) begin
            report_mismatch("link_up", result.link_up, want.link_up);
          end
          if (result.is_armed !== want.is_armed) begin
            report_mismatch("is_armed", result.is_armed, want.is_armed);
          end
          if (result.steering_out !== want.steering_out) begin
            report_mismatch("steering_out", result.steering_out, want.steering_out);
          end
          if (result.throttle_out !== want.throttle_out) begin
            report_mismatch("throttle_out", result.throttle_out, want.throttle_out);
          end
        end
      end
    end
  end

  initial begin : stimulus
    nom_lo[0] = STEER_MIN_RST;
    nom_hi[0] = STEER_MAX_RST;
    nom_lo[1] = THR_MIN_RST;
    nom_hi[1] = THR_MAX_RST;
    arm_level = AUX_RST;
    eps = EPS_RST;
    for (int i = 0; i < 4; i++) begin
      raw_prev[i] = '0;
      kept_width[i] = '0;
      cur_width[i] = '0;
    end
    for (int i = 0; i < 2; i++) begin
      edge_lo[i] = nom_lo[i];
      edge_hi[i] = nom_hi[i];
    end
    linked = 1'b0;
    armed = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items on the reset settings: timeouts, link, calibration,
    // saturation, deadband and a rejected glitch on the arm switch.
    queue_frame(0, 0, 0, 0);
    queue_frame(8191, 8191, 8191, 8191);
    queue_frame(5001, 5000, 5001, 5000);
    repeat (2) queue_frame(1500, 1500, 1000, 1000);
    repeat (2) queue_frame(900, 2100, 1000, 2000);
    queue_frame(880, 2120, 1000, 2000);
    repeat (2) queue_frame(1500, 1500, 2000, 1000);
    repeat (2) queue_frame(880, 2120, 2000, 1000);
    repeat (2) queue_frame(0, 0, 2000, 1000);
    repeat (2) queue_frame(1490, 1510, 2000, 1000);
    queue_frame(1495, 1505, 1400, 1000);
    repeat (2) queue_frame(4999, 1, 1400, 1000);
    wait_drained();

    run_phase(PHASE_ITEMS, 0, 0, 1'b0);

    // Widest and reversed ranges, switches always on, no glitch tolerance.
    write_reg(REG_STEER_MIN, 16'd0);
    write_reg(REG_STEER_MAX, 16'd5000);
    write_reg(REG_THROTTLE_MIN, 16'd5000);
    write_reg(REG_THROTTLE_MAX, 16'd0);
    write_reg(REG_AUX_THRESH, 16'd0);
    write_reg(REG_EPSILON, 16'd0);
    run_phase(PHASE_ITEMS, 66, 0, 1'b0);

    // Equal steering edges, highest threshold, widest tolerance.
    write_reg(REG_STEER_MIN, 16'd1500);
    write_reg(REG_STEER_MAX, 16'd1500);
    write_reg(REG_THROTTLE_MIN, 16'd1200);
    write_reg(REG_THROTTLE_MAX, 16'd1800);
    write_reg(REG_AUX_THRESH, 16'd5000);
    write_reg(REG_EPSILON, 16'hFFFF);
    run_phase(PHASE_ITEMS, 0, 66, 1'b0);

    // All ones on every index, the two unused ones included, then the upper
    // data bits set where only the low thirteen are kept.
    for (int i = 0; i < (1 << CFG_IW); i++) begin
      write_reg(i[CFG_IW-1:0], 16'hFFFF);
    end
    write_reg(REG_STEER_MIN, 16'hE000);
    write_reg(REG_THROTTLE_MIN, 16'h2000 | CFG_DW'($urandom_range(0, 2000)));
    write_reg(REG_AUX_THRESH, 16'h25DC);
    write_reg(REG_EPSILON, 16'd655);
    run_phase(PHASE_ITEMS, 19, 19, 1'b0);

    write_reg(REG_STEER_MIN, CFG_DW'(STEER_MIN_RST));
    write_reg(REG_STEER_MAX, CFG_DW'(STEER_MAX_RST));
    write_reg(REG_THROTTLE_MIN, CFG_DW'(THR_MIN_RST));
    write_reg(REG_THROTTLE_MAX, CFG_DW'(THR_MAX_RST));
    write_reg(REG_AUX_THRESH, CFG_DW'(AUX_RST));
    write_reg(REG_EPSILON, CFG_DW'(EPS_RST));
    run_phase(PHASE_ITEMS, 19, 19, 1'b1);

    write_reg(REG_STEER_MIN, CFG_DW'($urandom_range(500, 1500)));
    write_reg(REG_STEER_MAX, CFG_DW'($urandom_range(1500, 2500)));
    write_reg(REG_THROTTLE_MIN, CFG_DW'($urandom_range(500, 1500)));
    write_reg(REG_THROTTLE_MAX, CFG_DW'($urandom_range(1500, 2500)));
    write_reg(REG_AUX_THRESH, CFG_DW'($urandom_range(1000, 2000)));
    write_reg(REG_EPSILON, CFG_DW'($urandom_range(0, 65535)));
    run_phase(PHASE_ITEMS, 19, 19, 1'b0);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (predicted_results.size() != 0) begin
      report_mismatch("result items never delivered", 0, predicted_results.size());
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rpr_pkg.sv
rtl/rpr_div.sv
rtl/rpr_datapath.sv
rtl/rpr_ctrl.sv
rtl/rc_pwm_receiver_conditioner.sv
tb/tb_rc_pwm_receiver_conditioner.sv
